### src/dup_pkg.sv
// ----------------------------------------------------------------------------
// dup_pkg
// Shared types, character codes and lookup functions for the data-URI
// payload decoder.
// ----------------------------------------------------------------------------
package dup_pkg;

  localparam int unsigned OUT_FIFO_DEPTH = 4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PCT_ERR = 2'd1;
  localparam logic [1:0] ST_B64_ERR = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HIGH = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       end_of_payload;
  } result_t;

  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] count;
  } step_t;

  // {invalid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {invalid, value}
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - 8'h47)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c + 8'h04)};
    end else if (c == 8'h2B) begin
      r = 7'd62;
    end else if (c == 8'h2F) begin
      r = 7'd63;
    end
    return r;
  endfunction

endpackage

### src/dup_in_if.sv
// ----------------------------------------------------------------------------
// dup_in_if
// Character request channel: valid/ready with one payload character.
// ----------------------------------------------------------------------------
interface dup_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_final;

  modport source (output valid, output character, output is_final, input ready);
  modport sink   (input valid, input character, input is_final, output ready);
endinterface

### src/dup_out_if.sv
// ----------------------------------------------------------------------------
// dup_out_if
// Result request channel: valid/ready with one decoded result.
// ----------------------------------------------------------------------------
interface dup_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       end_of_payload;

  modport source (output valid, output data_byte, output byte_valid, output status,
                  output end_of_payload, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input status,
                  input end_of_payload, output ready);
endinterface

### src/data_uri_payload_decoder.sv
// ----------------------------------------------------------------------------
// data_uri_payload_decoder
// Data-URI payload decoder: one character in, decoded bytes out, in percent
// or base64 mode as set by the mode register.
//
//   channel  dir  payload                                          
//   in_ch    in   character[7:0], is_final                         
//   out_ch   out  data_byte[7:0], byte_valid, status[1:0], end_of_payload
//   cfg      in   cfg_we, cfg_wdata (base64_mode)                  
//
// While in_ch.ready is high, one character is accepted per cycle; its results
// enter the result queue at that edge; the head is presented the next cycle.
// A character yields 0, 1 or 2 results, which drain one per ready cycle.
// in_ch.ready drops while the result queue has fewer than two free slots.
// Reset (rst_n low, synchronous) empties the queue and clears decode state.
// ----------------------------------------------------------------------------
module data_uri_payload_decoder #(
  parameter int unsigned FIFO_DEPTH = dup_pkg::OUT_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  dup_in_if.sink     in_ch,
  dup_out_if.source  out_ch
);
  import dup_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(FIFO_DEPTH - 2);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  step_t            step;
  logic             accept;
  logic             pop;
  logic [1:0]       push_n;
  result_t          fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  result_t          head;

  assign in_ch.ready = (cnt_r <= ROOM_MAX);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;
  assign push_n      = accept ? step.count : 2'd0;

  dup_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .character (in_ch.character),
    .is_final  (in_ch.is_final),
    .step      (step)
  );

  always_comb begin
    wr_ptr_1   = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr_ptr_1;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= step.res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_1] <= step.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head                  = fifo_r[rd_ptr_r];
  assign out_ch.valid          = (cnt_r != '0);
  assign out_ch.data_byte      = head.data_byte;
  assign out_ch.byte_valid     = head.byte_valid;
  assign out_ch.status         = head.status;
  assign out_ch.end_of_payload = head.end_of_payload;

endmodule

### src/dup_decode.sv
// ----------------------------------------------------------------------------
// dup_decode
// Decode state and per-character step logic: percent escapes and base64
// accumulation, producing up to two results per accepted character.
// ----------------------------------------------------------------------------
module dup_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            accept,
  input  logic [7:0]      character,
  input  logic            is_final,
  output dup_pkg::step_t  step
);
  import dup_pkg::*;

  logic        mode_r;
  logic [11:0] acc_r, acc_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        pad_r, pad_nxt;
  logic [1:0]  esc_r, esc_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        err_r, err_nxt;

  logic [4:0]  hi, lo;
  logic [6:0]  bv;
  logic [3:0]  nbits;
  logic [2:0]  pend_sub;

  always_comb begin
    hi       = hex_value(held_r);
    lo       = hex_value(character);
    bv       = b64_value(character);
    nbits    = {1'b0, pend_r} + 4'd6;
    pend_sub = 3'(nbits - 4'd8);

    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    pad_nxt  = pad_r;
    esc_nxt  = esc_r;
    held_nxt = held_r;
    err_nxt  = err_r;
    step     = '0;

    if (!err_r) begin
      if (mode_r) begin
        if (pad_r) begin
          step.count = 2'd0;
        end else if (character == CH_PAD) begin
          pad_nxt  = 1'b1;
          acc_nxt  = '0;
          pend_nxt = '0;
        end else if (bv[6]) begin
          err_nxt    = 1'b1;
          step.res0  = '{8'h00, 1'b0, ST_B64_ERR, is_final};
          step.count = 2'd1;
        end else begin
          acc_nxt = {acc_r[5:0], bv[5:0]};
          if (nbits >= 4'd8) begin
            pend_nxt   = pend_sub;
            step.res0  = '{8'(acc_nxt >> pend_sub), 1'b1, ST_OK, is_final};
            step.count = 2'd1;
          end else begin
            pend_nxt = nbits[2:0];
          end
        end
      end else begin
        case (esc_r)
          ESC_NONE: begin
            if (character == CH_PERCENT && !is_final) begin
              esc_nxt = ESC_PCT;
            end else begin
              step.res0  = '{character, 1'b1, ST_OK, is_final};
              step.count = 2'd1;
            end
          end
          ESC_PCT: begin
            if (is_final) begin
              step.res0  = '{CH_PERCENT, 1'b1, ST_OK, 1'b0};
              step.res1  = '{character, 1'b1, ST_OK, 1'b1};
              step.count = 2'd2;
              esc_nxt    = ESC_NONE;
            end else begin
              held_nxt = character;
              esc_nxt  = ESC_HIGH;
            end
          end
          default: begin
            esc_nxt    = ESC_NONE;
            step.count = 2'd1;
            if (hi[4] || lo[4]) begin
              err_nxt   = 1'b1;
              step.res0 = '{8'h00, 1'b0, ST_PCT_ERR, is_final};
            end else begin
              step.res0 = '{{hi[3:0], lo[3:0]}, 1'b1, ST_OK, is_final};
            end
          end
        endcase
      end
    end

    if (is_final) begin
      if (step.count == 2'd0) begin
        step.res0  = '{8'h00, 1'b0, ST_OK, 1'b1};
        step.count = 2'd1;
      end
      acc_nxt  = '0;
      pend_nxt = '0;
      pad_nxt  = 1'b0;
      esc_nxt  = ESC_NONE;
      held_nxt = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      acc_r  <= '0;
      pend_r <= '0;
      pad_r  <= 1'b0;
      esc_r  <= ESC_NONE;
      held_r <= '0;
      err_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        acc_r  <= acc_nxt;
        pend_r <= pend_nxt;
        pad_r  <= pad_nxt;
        esc_r  <= esc_nxt;
        held_r <= held_nxt;
        err_r  <= err_nxt;
      end
    end
  end

endmodule

### src/dup_checker.sv
// ----------------------------------------------------------------------------
// dup_checker
// Port-level checks for the data-URI payload decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dup_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic [1:0] out_status,
  input logic       out_end
);
  import dup_pkg::*;

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  a_error_has_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_byte_valid && out_data_byte == 8'h00)
    else $error("error result carries a byte");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_data_byte == 8'h00)
    else $error("result without byte has nonzero data");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_PCT_ERR ||
                  out_status == ST_B64_ERR)
    else $error("illegal status code");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
                                $stable(out_status) && $stable(out_end))
    else $error("stalled result changed");

endmodule

bind data_uri_payload_decoder dup_checker u_dup_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_data_byte  (out_ch.data_byte),
  .out_byte_valid (out_ch.byte_valid),
  .out_status     (out_ch.status),
  .out_end        (out_ch.end_of_payload)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the data-URI payload decoder. Directed payloads
// cover the escape and base64 corner cases. Random payloads follow in both
// modes, with mode switches between idle phases. Every accepted character is
// run through a local decoder model, and each result request is checked
// against the oldest predicted result. Both channels stall at random, and
// one long result back-pressure stretch fills the block.
// ----------------------------------------------------------------------------
module tb;
  import dup_pkg::*;

  typedef struct packed {
    logic [7:0] character;
    logic       is_final;
  } char_req_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  dup_in_if  in_ch ();
  dup_out_if out_ch ();

  data_uri_payload_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  char_req_t char_q[$];
  result_t   decoded_q[$];
  int        idle_pct = 13;
  int        n_queued = 0;
  int        n_mismatch = 0;
  int        n_results = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  result_t   seen_res;
  result_t   want_res;

  // decoder model state
  logic        b64_mode = 1'b0;
  logic [11:0] acc = '0;
  logic [2:0]  acc_bits = '0;
  logic        pad_hit = 1'b0;
  logic [1:0]  esc_state = ESC_NONE;
  logic [7:0]  esc_high = '0;
  logic        err_hold = 1'b0;

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string hex_alpha = "0123456789abcdefABCDEF";

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b0, c[3:0] + 4'd9};
    end
    return 5'h10;
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic v,
                                     input logic [1:0] st, input logic last);
    result_t r;
    r.data_byte      = v ? b : 8'h00;
    r.byte_valid     = v;
    r.status         = st;
    r.end_of_payload = last;
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic fin);
    int         produced;
    int         sext;
    int         nb;
    logic [4:0] hi;
    logic [4:0] lo;
    produced = 0;
    if (!err_hold) begin
      if (b64_mode) begin
        if (!pad_hit) begin
          if (c == CH_PAD) begin
            pad_hit  = 1'b1;
            acc      = '0;
            acc_bits = '0;
          end else begin
            if (c >= 8'h41 && c <= 8'h5A) sext = c - 8'h41;
            else if (c >= 8'h61 && c <= 8'h7A) sext = c - 8'h61 + 26;
            else if (c >= 8'h30 && c <= 8'h39) sext = c - 8'h30 + 52;
            else if (c == 8'h2B) sext = 62;
            else if (c == 8'h2F) sext = 63;
            else sext = -1;
            if (sext < 0) begin
              err_hold = 1'b1;
              add_result(8'h00, 1'b0, ST_B64_ERR, fin);
              produced = 1;
            end else begin
              acc = {acc[5:0], 6'(sext)};
              nb  = acc_bits + 6;
              if (nb >= 8) begin
                nb -= 8;
                add_result(8'(acc >> nb), 1'b1, ST_OK, fin);
                produced = 1;
              end
              acc_bits = 3'(nb);
            end
          end
        end
      end else begin
        case (esc_state)
          ESC_NONE: begin
            if (c == CH_PERCENT && !fin) begin
              esc_state = ESC_PCT;
            end else begin
              add_result(c, 1'b1, ST_OK, fin);
              produced = 1;
            end
          end
          ESC_PCT: begin
            if (fin) begin
              add_result(CH_PERCENT, 1'b1, ST_OK, 1'b0);
              add_result(c, 1'b1, ST_OK, 1'b1);
              esc_state = ESC_NONE;
              produced  = 2;
            end else begin
              esc_high  = c;
              esc_state = ESC_HIGH;
            end
          end
          default: begin
            hi = nibble_of(esc_high);
            lo = nibble_of(c);
            esc_state = ESC_NONE;
            if (hi[4] || lo[4]) begin
              err_hold = 1'b1;
              add_result(8'h00, 1'b0, ST_PCT_ERR, fin);
            end else begin
              add_result({hi[3:0], lo[3:0]}, 1'b1, ST_OK, fin);
            end
            produced = 1;
          end
        endcase
      end
    end
    if (fin) begin
      if (produced == 0) add_result(8'h00, 1'b0, ST_OK, 1'b1);
      acc       = '0;
      acc_bits  = '0;
      pad_hit   = 1'b0;
      esc_state = ESC_NONE;
      esc_high  = '0;
      err_hold  = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    n_mismatch++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_char(in_ch.character, in_ch.is_final);
        void'(char_q.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.character <= char_q[0].character;
          in_ch.is_final  <= char_q[0].is_final;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        seen_res = {out_ch.data_byte, out_ch.byte_valid, out_ch.status, out_ch.end_of_payload};
        if (decoded_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %h", seen_res));
        end else begin
          want_res = decoded_q.pop_front();
          if (seen_res.data_byte !== want_res.data_byte)
            flag_mismatch($sformatf("data_byte %h, want %h",
                                    seen_res.data_byte, want_res.data_byte));
          if (seen_res.byte_valid !== want_res.byte_valid)
            flag_mismatch($sformatf("byte_valid %b, want %b",
                                    seen_res.byte_valid, want_res.byte_valid));
          if (seen_res.status !== want_res.status)
            flag_mismatch($sformatf("status %0d, want %0d",
                                    seen_res.status, want_res.status));
          if (seen_res.end_of_payload !== want_res.end_of_payload)
            flag_mismatch($sformatf("end_of_payload %b, want %b",
                                    seen_res.end_of_payload, want_res.end_of_payload));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && n_results >= 400 && in_ch.valid) begin
        hold_done = 1'b1;
        hold_left = 250;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    char_req_t r;
    r.character = c;
    r.is_final  = fin;
    char_q.insert(char_q.size(), r);
    n_queued++;
  endtask

  task automatic send_str(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], fin_last && (i == s.len() - 1));
  endtask

  task automatic wait_drained;
    do @(negedge clk); while (char_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    b64_mode = m;
    @(negedge clk);
  endtask

  task automatic gen_payload(input bit with_fin);
    logic [7:0] chars[$];
    logic [7:0] c;
    int         n;
    int         r;
    if (!b64_mode) begin
      n = $urandom_range(1, 10);
      while (chars.size() < n) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          c = 8'($urandom_range(0, 255));
          chars.insert(chars.size(), (c == CH_PERCENT) ? 8'h41 : c);
        end else if (r < 90) begin
          chars.insert(chars.size(), CH_PERCENT);
          chars.insert(chars.size(), hex_alpha[$urandom_range(0, 21)]);
          chars.insert(chars.size(), hex_alpha[$urandom_range(0, 21)]);
        end else if (r < 97) begin
          chars.insert(chars.size(), CH_PERCENT);
          chars.insert(chars.size(), 8'($urandom_range(0, 255)));
          chars.insert(chars.size(), 8'($urandom_range(0, 255)));
        end else begin
          chars.insert(chars.size(), CH_PERCENT);
        end
      end
      // cutting an escape short exercises the near-end literal path
      while (chars.size() > n) void'(chars.pop_back());
    end else begin
      n = $urandom_range(1, 16);
      while (chars.size() < n) begin
        r = $urandom_range(0, 999);
        if (r < 960) chars.insert(chars.size(), b64_alpha[$urandom_range(0, 63)]);
        else if (r < 985) chars.insert(chars.size(), CH_PAD);
        else chars.insert(chars.size(), 8'($urandom_range(0, 255)));
      end
    end
    foreach (chars[i]) send_char(chars[i], with_fin && (i == chars.size() - 1));
  endtask

  initial begin
    int phase;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.character = 8'h00;
    in_ch.is_final  = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_mode(1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_str("%4a%g1x", 1'b1);
    send_str("%1x", 1'b1);
    send_str("%Z", 1'b1);
    send_str("%", 1'b1);
    wait_drained();

    write_mode(1'b1);
    send_str("TWFu+/9=Q", 1'b1);
    send_str("Q*A", 1'b1);
    send_str("QU", 1'b0);
    wait_drained();
    // mode switches inside one payload
    write_mode(1'b0);
    send_str("%4", 1'b0);
    wait_drained();
    write_mode(1'b1);
    send_str("E", 1'b0);
    wait_drained();
    write_mode(1'b0);
    send_str("1", 1'b1);
    wait_drained();

    phase = 0;
    while (n_queued < 1850) begin
      phase++;
      idle_pct = (phase == 3) ? 0 : 13;
      repeat ((phase == 3) ? 30 : $urandom_range(3, 8)) gen_payload(1'b1);
      if ($urandom_range(0, 3) == 0) gen_payload(1'b0);
      wait_drained();
      write_mode(1'($urandom_range(0, 1)));
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
